// ===== rtl/ovle_pkg.sv =====
// ----------------------------------------------------------------------------
// ovle_pkg: shared types for the ordered value list engine
// Request kinds, result status codes and sequencer states.
// ----------------------------------------------------------------------------
package ovle_pkg;

   // Width of the value field and of the packed result fields.
   localparam int VALUE_W    = 32;
   localparam int KIND_W     = 2;
   localparam int STATUS_W   = 2;
   localparam int POS_W      = 5;
   localparam int RSP_DATA_W = 16;

   // Request kinds carried on req_tuser.
   typedef enum logic [KIND_W-1:0] {
      KIND_PUSH   = 2'd0,
      KIND_REMOVE = 2'd1,
      KIND_LOOKUP = 2'd2,
      KIND_CLEAR  = 2'd3
   } kind_type;

   // Result status carried on rsp_tuser.
   typedef enum logic [STATUS_W-1:0] {
      STATUS_OK        = 2'd0,
      STATUS_NOT_FOUND = 2'd1,
      STATUS_FULL      = 2'd2
   } status_type;

   // Sequencer states.
   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SEARCH,
      ST_SHIFT,
      ST_FINISH
   } state_type;

endpackage

// ===== rtl/ovle_ram.sv =====
// ----------------------------------------------------------------------------
// ovle_ram: list entry storage
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module ovle_ram
   import ovle_pkg::*;
#(
   parameter int DEPTH = 16,
   parameter int AW    = 4
) (
   input  logic               clock,
   input  logic               wr_en,
   input  logic [AW-1:0]      wr_addr,
   input  logic [VALUE_W-1:0] wr_data,
   input  logic [AW-1:0]      rd_addr,
   output logic [VALUE_W-1:0] rd_data
);

   logic [VALUE_W-1:0] mem [DEPTH];
   logic [VALUE_W-1:0] rd_data_ff;

   // Write port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // Read port, with the read data registered.
   always_ff @(posedge clock) begin
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/ordered_value_list_engine.sv =====
// ----------------------------------------------------------------------------
// ordered_value_list_engine: bounded ordered list of signed 32-bit values
// Push to front, remove first match, look up position and clear, one result
// beat for every request beat.
// ----------------------------------------------------------------------------
// The list lives in a single-port-read, single-port-write memory used as a
// ring: the front slot is tracked by a head pointer, so a push is one memory
// write. Requests are handled one at a time and req_tready is high only while
// the sequencer is idle. A push or a clear goes from idle straight to the
// finish state, which loads the result register, and so does a remove or
// lookup on an empty list. A lookup scans entries from the front through one
// shared comparator, one entry per cycle, until it finds a match or passes
// the last entry. A remove then moves the entries behind the match up by one
// slot through the memory's single read and write ports, so a remove that
// hits the front of a full list of DEPTH entries is the longest case. The
// result waits in an output register, and the next request is accepted once
// it has been loaded there; a stalled result register holds the sequencer
// until it drains.
// No clearing pass is needed after reset: entries are only read below count.
// ----------------------------------------------------------------------------
module ordered_value_list_engine
   import ovle_pkg::*;
#(
   parameter int DEPTH = 16
) (
   input  logic                  clock,
   input  logic                  reset,
   // Request channel.
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [VALUE_W-1:0]    req_tdata,   // [31:0] value
   input  logic [KIND_W-1:0]     req_tuser,   // [1:0] kind
   // Result channel.
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata,   // [4:0] position, [9:5] count,
                                              // [10] empty_res, [15:11] zero
   output logic [STATUS_W-1:0]   rsp_tuser    // [1:0] status
);

   localparam int AW = $clog2(DEPTH);
   localparam int CW = $clog2(DEPTH + 1);

   // Ring pointer steps with wrap at DEPTH.
   function automatic logic [AW-1:0] ring_next(input logic [AW-1:0] p);
      ring_next = (p == AW'(DEPTH - 1)) ? '0 : p + 1'b1;
   endfunction

   function automatic logic [AW-1:0] ring_prev(input logic [AW-1:0] p);
      ring_prev = (p == '0) ? AW'(DEPTH - 1) : p - 1'b1;
   endfunction

   // Control registers.
   state_type           state_ff, state_in;
   logic [AW-1:0]       head_ff, head_in;
   logic [CW-1:0]       count_ff, count_in;
   logic                cmp_vld_ff, cmp_vld_in;
   logic                rsp_valid_ff, rsp_valid_in;

   // Payload registers.
   logic [VALUE_W-1:0]  key_ff, key_in;
   kind_type            kind_ff, kind_in;
   logic [CW-1:0]       scan_idx_ff, scan_idx_in;
   logic [AW-1:0]       scan_phys_ff, scan_phys_in;
   logic [AW-1:0]       cmp_phys_ff, cmp_phys_in;
   status_type          res_status_ff, res_status_in;
   logic [CW-1:0]       res_pos_ff, res_pos_in;
   status_type          rsp_status_ff, rsp_status_in;
   logic [POS_W-1:0]    rsp_pos_ff, rsp_pos_in;
   logic [POS_W-1:0]    rsp_count_ff, rsp_count_in;
   logic                rsp_empty_ff, rsp_empty_in;

   // Memory ports.
   logic                wr_en;
   logic [AW-1:0]       wr_addr;
   logic [VALUE_W-1:0]  wr_data;
   logic [VALUE_W-1:0]  rd_data;

   logic                req_accept;
   logic                rsp_free;
   logic                match;
   kind_type            req_kind;

   assign req_kind   = kind_type'(req_tuser);
   assign req_tready = (state_ff == ST_IDLE);
   assign req_accept = req_tvalid && req_tready;
   assign rsp_free   = !rsp_valid_ff || rsp_tready;

   // The one shared comparator: stored entry against the search key.
   assign match = (rd_data == key_ff);

   ovle_ram #(
      .DEPTH (DEPTH),
      .AW    (AW)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (scan_phys_ff),
      .rd_data (rd_data)
   );

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               if ((req_kind == KIND_REMOVE || req_kind == KIND_LOOKUP) &&
                   count_ff != '0) begin
                  state_in = ST_SEARCH;
               end else begin
                  state_in = ST_FINISH;
               end
            end
         end
         ST_SEARCH: begin
            if (cmp_vld_ff && match) begin
               state_in = (kind_ff == KIND_REMOVE) ? ST_SHIFT : ST_FINISH;
            end else if (cmp_vld_ff && scan_idx_ff == count_ff) begin
               state_in = ST_FINISH;
            end
         end
         ST_SHIFT: begin
            if (scan_idx_ff >= count_ff && !cmp_vld_ff) begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (rsp_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Datapath and output values for each state.
   always_comb begin
      head_in       = head_ff;
      count_in      = count_ff;
      cmp_vld_in    = cmp_vld_ff;
      key_in        = key_ff;
      kind_in       = kind_ff;
      scan_idx_in   = scan_idx_ff;
      scan_phys_in  = scan_phys_ff;
      cmp_phys_in   = cmp_phys_ff;
      res_status_in = res_status_ff;
      res_pos_in    = res_pos_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      rsp_status_in = rsp_status_ff;
      rsp_pos_in    = rsp_pos_ff;
      rsp_count_in  = rsp_count_ff;
      rsp_empty_in  = rsp_empty_ff;
      wr_en         = 1'b0;
      wr_addr       = ring_prev(head_ff);
      wr_data       = req_tdata;

      case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               key_in        = req_tdata;
               kind_in       = req_kind;
               scan_idx_in   = '0;
               scan_phys_in  = head_ff;
               cmp_vld_in    = 1'b0;
               res_pos_in    = '0;
               res_status_in = STATUS_OK;
               case (req_kind)
                  KIND_PUSH: begin
                     if (count_ff == CW'(DEPTH)) begin
                        res_status_in = STATUS_FULL;
                     end else begin
                        wr_en    = 1'b1;
                        head_in  = ring_prev(head_ff);
                        count_in = count_ff + 1'b1;
                     end
                  end
                  KIND_REMOVE, KIND_LOOKUP: begin
                     if (count_ff == '0) begin
                        res_status_in = STATUS_NOT_FOUND;
                     end
                  end
                  KIND_CLEAR: begin
                     count_in = '0;
                  end
                  default: begin
                     count_in = count_ff;
                  end
               endcase
            end
         end
         ST_SEARCH: begin
            if (cmp_vld_ff && match) begin
               // Position is one past the matching index. The scan pointer
               // already names the entry behind the match, which is where a
               // remove starts moving entries up.
               res_pos_in = scan_idx_ff;
               cmp_vld_in = 1'b0;
            end else if (cmp_vld_ff && scan_idx_ff == count_ff) begin
               res_status_in = STATUS_NOT_FOUND;
            end else begin
               cmp_phys_in  = scan_phys_ff;
               scan_phys_in = ring_next(scan_phys_ff);
               scan_idx_in  = scan_idx_ff + 1'b1;
               cmp_vld_in   = 1'b1;
            end
         end
         ST_SHIFT: begin
            // The entry read last cycle moves into the slot in front of it.
            if (cmp_vld_ff) begin
               wr_en       = 1'b1;
               wr_addr     = cmp_phys_ff;
               wr_data     = rd_data;
               cmp_phys_in = ring_next(cmp_phys_ff);
            end
            if (scan_idx_ff < count_ff) begin
               scan_phys_in = ring_next(scan_phys_ff);
               scan_idx_in  = scan_idx_ff + 1'b1;
               cmp_vld_in   = 1'b1;
            end else begin
               cmp_vld_in = 1'b0;
               if (!cmp_vld_ff) begin
                  count_in = count_ff - 1'b1;
               end
            end
         end
         ST_FINISH: begin
            if (rsp_free) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = res_status_ff;
               rsp_pos_in    = POS_W'(res_pos_ff);
               rsp_count_in  = POS_W'(count_ff);
               rsp_empty_in  = (count_ff == '0);
            end
         end
         default: begin
            rsp_valid_in = rsp_valid_ff && !rsp_tready;
         end
      endcase
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         head_ff      <= '0;
         count_ff     <= '0;
         cmp_vld_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         head_ff      <= head_in;
         count_ff     <= count_in;
         cmp_vld_ff   <= cmp_vld_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      key_ff        <= key_in;
      kind_ff       <= kind_in;
      scan_idx_ff   <= scan_idx_in;
      scan_phys_ff  <= scan_phys_in;
      cmp_phys_ff   <= cmp_phys_in;
      res_status_ff <= res_status_in;
      res_pos_ff    <= res_pos_in;
      rsp_status_ff <= rsp_status_in;
      rsp_pos_ff    <= rsp_pos_in;
      rsp_count_ff  <= rsp_count_in;
      rsp_empty_ff  <= rsp_empty_in;
   end

   // Result beat packing.
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_status_ff;
   assign rsp_tdata  = {{(RSP_DATA_W - 2 * POS_W - 1){1'b0}},
                        rsp_empty_ff, rsp_count_ff, rsp_pos_ff};

endmodule

// ===== rtl/ovle_checker.sv =====
// ----------------------------------------------------------------------------
// ovle_checker: port-level checks for the ordered value list engine
// Watches the request and result channels and is bound to the top level.
// ----------------------------------------------------------------------------
module ovle_checker
   import ovle_pkg::*;
(
   input logic                  clock,
   input logic                  reset,
   input logic                  req_tvalid,
   input logic                  req_tready,
   input logic                  rsp_tvalid,
   input logic                  rsp_tready,
   input logic [RSP_DATA_W-1:0] rsp_tdata,
   input logic [STATUS_W-1:0]   rsp_tuser
);

   // A stalled result beat holds its contents.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=>
         rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
   else $error("result beat changed while stalled");

   // The empty flag agrees with the count in the same beat.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tdata[10] == (rsp_tdata[9:5] == 5'd0)))
   else $error("empty flag disagrees with count");

   // Not-found and rejected results carry no position.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser != STATUS_OK |-> rsp_tdata[4:0] == 5'd0)
   else $error("position reported on a failed request");

   // Requests are taken one at a time: no accept in the cycle after one.
   assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
   else $error("request accepted while busy");

endmodule

bind ordered_value_list_engine ovle_checker u_ovle_checker (.*);

// ===== bench/ordered_value_list_engine_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// ordered_value_list_engine_tb: self-checking bench for the ordered value list
// Drives push, remove, lookup and clear beats into the block and keeps its own
// copy of the list. Each request beat yields one expected result, which is
// compared field by field with the result beats as they leave the block.
// Directed cases come first, then a long hold-off on the result side, then
// random traffic under several idle and stall mixes.
// ----------------------------------------------------------------------------
module ordered_value_list_engine_tb;
   import ovle_pkg::*;

   localparam int LIST_DEPTH  = 16;
   localparam int POOL_SIZE   = 8;
   localparam int HOLD_CYCLES = 300;
   localparam int CYCLE_LIMIT = 1_000_000;
   localparam int MAX_GAP     = 24;

   // One expected result beat.
   typedef struct packed {
      status_type        status;
      logic [POS_W-1:0]  position;
      logic [POS_W-1:0]  count;
      logic              empty_res;
   } list_result_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [VALUE_W-1:0]    req_tdata = '0;    // [31:0] value
   logic [KIND_W-1:0]     req_tuser = '0;    // [1:0] kind
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;         // [4:0] position, [9:5] count,
                                             // [10] empty_res
   logic [STATUS_W-1:0]   rsp_tuser;         // [1:0] status

   // Shadow copy of the list held by the block.
   logic [VALUE_W-1:0] list_model [LIST_DEPTH];
   int                 list_count = 0;
   logic [VALUE_W-1:0] value_pool [POOL_SIZE];

   list_result_type expected_results [$];
   int              fail_count = 0;
   int              sender_idle_pct = 0;
   int              receiver_stall_pct = 0;
   logic            hold_toggle = 1'b0;

   ordered_value_list_engine #(
      .DEPTH(LIST_DEPTH)
   ) u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   initial begin : clock_gen
      forever #6 clock = ~clock;
   end

   // Apply one request to the shadow list and return the result it causes.
   function automatic list_result_type apply_to_list(kind_type kind,
                                                     logic [VALUE_W-1:0] value);
      list_result_type res;
      int              slot;
      res.status   = STATUS_OK;
      res.position = '0;
      slot = -1;
      for (int i = 0; i < list_count; i++) begin
         if (slot < 0 && list_model[i] == value) slot = i;
      end
      case (kind)
         KIND_PUSH: begin
            if (list_count >= LIST_DEPTH) begin
               res.status = STATUS_FULL;
            end else begin
               for (int i = list_count; i > 0; i--) list_model[i] = list_model[i-1];
               list_model[0] = value;
               list_count++;
            end
         end
         KIND_REMOVE: begin
            if (slot < 0) begin
               res.status = STATUS_NOT_FOUND;
            end else begin
               res.position = POS_W'(slot + 1);
               for (int i = slot; i + 1 < list_count; i++) list_model[i] = list_model[i+1];
               list_count--;
            end
         end
         KIND_LOOKUP: begin
            if (slot < 0) res.status = STATUS_NOT_FOUND;
            else res.position = POS_W'(slot + 1);
         end
         default: begin
            list_count = 0;
         end
      endcase
      res.count     = POS_W'(list_count);
      res.empty_res = (list_count == 0);
      return res;
   endfunction

   // Random idle gap before the next request beat.
   function automatic int pick_gap();
      int gap;
      gap = 0;
      while (gap < MAX_GAP && $urandom_range(99) < sender_idle_pct) gap++;
      return gap;
   endfunction

   // Offer one request beat and wait until the block takes it.
   task automatic send_request(kind_type kind, logic [VALUE_W-1:0] value);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         @(negedge clock);
         req_tvalid <= 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
      @(negedge clock);
      req_tvalid <= 1'b1;
      req_tdata  <= value;
      req_tuser  <= kind;
      do @(posedge clock); while (!req_tready);
      expected_results.push_back(apply_to_list(kind, value));
   endtask

   // Result side: random stalls, and a long hold-off whenever one is asked.
   initial begin : result_receiver
      int   hold_left;
      logic seen_toggle;
      hold_left   = 0;
      seen_toggle = hold_toggle;
      forever begin
         @(negedge clock);
         if (hold_toggle != seen_toggle) begin
            seen_toggle = hold_toggle;
            hold_left   = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= ($urandom_range(99) >= receiver_stall_pct);
         end
      end
   end

   // Compare every result beat with the oldest expected result.
   always @(posedge clock) begin : result_checker
      list_result_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_results.size() == 0) begin
            $error("result beat with no request pending: status %0d data %0h",
                   rsp_tuser, rsp_tdata);
            fail_count++;
         end else begin
            want = expected_results.pop_front();
            if (rsp_tuser !== want.status) begin
               $error("status expected %0d actual %0d", want.status, rsp_tuser);
               fail_count++;
            end
            if (rsp_tdata[4:0] !== want.position) begin
               $error("position expected %0d actual %0d", want.position, rsp_tdata[4:0]);
               fail_count++;
            end
            if (rsp_tdata[9:5] !== want.count) begin
               $error("count expected %0d actual %0d", want.count, rsp_tdata[9:5]);
               fail_count++;
            end
            if (rsp_tdata[10] !== want.empty_res) begin
               $error("empty_res expected %0d actual %0d", want.empty_res, rsp_tdata[10]);
               fail_count++;
            end
         end
      end
   end

   // Watchdog on the whole run.
   initial begin : watchdog
      int cycles;
      cycles = 0;
      while (cycles < CYCLE_LIMIT) begin
         @(posedge clock);
         cycles++;
      end
      $display("[ordered_value_list_engine] ERROR");
      $finish;
   end

   // Empty-list cases, the value extremes, a full list and first-match rules.
   task automatic test_directed();
      logic [VALUE_W-1:0] fill [LIST_DEPTH];
      fill = '{32'h8000_0000, 32'h7FFF_FFFF, 32'h0000_0000, 32'hFFFF_FFFF,
               32'h0000_0005, 32'hDEAD_BEEF, 32'h0000_0005, 32'h5555_5555,
               32'hAAAA_AAAA, 32'h0000_0001, 32'h8000_0001, 32'h7FFF_FFFE,
               32'h0000_0005, 32'h1234_5678, 32'hFFFF_FFFE, 32'h0F0F_0F0F};
      sender_idle_pct    = 0;
      receiver_stall_pct = 0;
      send_request(KIND_CLEAR, 32'h0);
      send_request(KIND_LOOKUP, 32'h0);
      send_request(KIND_REMOVE, 32'hFFFF_FFFF);
      foreach (fill[i]) send_request(KIND_PUSH, fill[i]);
      // The list is full now, so this push bounces.
      send_request(KIND_PUSH, 32'h4242_4242);
      send_request(KIND_LOOKUP, 32'h8000_0000);
      send_request(KIND_REMOVE, 32'h0000_0005);
      send_request(KIND_REMOVE, 32'h8000_0000);
      send_request(KIND_LOOKUP, 32'h4242_4242);
      send_request(KIND_CLEAR, 32'hFFFF_FFFF);
   endtask

   // Hold the result side off while the request side keeps offering beats.
   task automatic test_backpressure();
      sender_idle_pct    = 0;
      receiver_stall_pct = 0;
      @(posedge clock);
      hold_toggle = ~hold_toggle;
      for (int i = 0; i < 12; i++) begin
         if (i % 3 == 2) send_request(KIND_LOOKUP, value_pool[$urandom_range(POOL_SIZE-1)]);
         else send_request(KIND_PUSH, value_pool[$urandom_range(POOL_SIZE-1)]);
      end
   endtask

   // Random traffic with a biased mix that fills and drains the list in turns.
   task automatic run_random_traffic(int beats, int idle_pct, int stall_pct);
      kind_type           kind;
      logic [VALUE_W-1:0] value;
      int                 push_weight;
      int                 r;
      sender_idle_pct    = idle_pct;
      receiver_stall_pct = stall_pct;
      value_pool[0] = 32'h8000_0000;
      value_pool[1] = 32'h7FFF_FFFF;
      value_pool[2] = 32'h0000_0000;
      value_pool[3] = 32'hFFFF_FFFF;
      for (int i = 4; i < POOL_SIZE; i++) value_pool[i] = $urandom;
      push_weight = 45;
      for (int n = 0; n < beats; n++) begin
         if (n % 32 == 0) push_weight = $urandom_range(20, 75);
         r = $urandom_range(99);
         if (r < push_weight) kind = KIND_PUSH;
         else if (r >= 98) kind = KIND_CLEAR;
         else if (r % 2 == 0) kind = KIND_REMOVE;
         else kind = KIND_LOOKUP;
         r = $urandom_range(99);
         if (kind != KIND_PUSH && list_count > 0 && r < 50)
            value = list_model[$urandom_range(list_count - 1)];
         else if (r < 80)
            value = value_pool[$urandom_range(POOL_SIZE-1)];
         else
            value = $urandom;
         send_request(kind, value);
      end
   endtask

   task automatic test_random_no_idle();
      run_random_traffic(488, 0, 0);
   endtask

   task automatic test_random_sender_idle();
      run_random_traffic(488, 67, 0);
   endtask

   task automatic test_random_receiver_stall();
      run_random_traffic(488, 0, 67);
   endtask

   task automatic test_random_both_idle();
      run_random_traffic(488, 16, 16);
   endtask

   initial begin : main_sequence
      for (int i = 0; i < POOL_SIZE; i++) value_pool[i] = $urandom;
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      test_directed();
      test_backpressure();
      test_random_no_idle();
      test_random_sender_idle();
      test_random_receiver_stall();
      test_random_both_idle();
      @(negedge clock);
      req_tvalid <= 1'b0;
      // Drain, then give the block time to show any stray result beat.
      while (expected_results.size() != 0) @(posedge clock);
      repeat (40) @(posedge clock);
      if (fail_count == 0) begin
         $display("[ordered_value_list_engine] OK");
      end else begin
         $display("[ordered_value_list_engine] ERROR");
      end
      $finish;
   end

endmodule
